/* sv/ctgs_pkg.sv */
// Package for the contig length statistics unit.
// Shared widths, statistic codes, register indexes and control structs.
// No dependencies.
`default_nettype none
package ctgs_pkg;
  localparam int MAX_CONTIGS = 4096;
  localparam int ADDR_W = $clog2(MAX_CONTIGS);
  localparam int CNT_W = ADDR_W + 1;
  localparam int LEN_W = 31;
  localparam int RD_W = 20;
  localparam int CFGD_W = 32;
  localparam int SUM_W = LEN_W + CNT_W;
  localparam int RSUM_W = RD_W + CNT_W;
  localparam int VAL_W = 48;
  localparam int SID_W = 5;
  localparam int KMUL_W = 14;
  localparam int NUM_W = SUM_W + KMUL_W;
  localparam int BIT_W = 5;

  localparam logic [0:0] CFG_THRESH = 1'b0;
  localparam logic [0:0] CFG_READS  = 1'b1;

  localparam logic [SID_W-1:0] ST_CNT      = 5'd0;
  localparam logic [SID_W-1:0] ST_BASES    = 5'd1;
  localparam logic [SID_W-1:0] ST_MEAN     = 5'd2;
  localparam logic [SID_W-1:0] ST_MIN      = 5'd3;
  localparam logic [SID_W-1:0] ST_MAX      = 5'd4;
  localparam logic [SID_W-1:0] ST_N50      = 5'd5;
  localparam logic [SID_W-1:0] ST_LG_CNT   = 5'd6;
  localparam logic [SID_W-1:0] ST_LG_BASES = 5'd7;
  localparam logic [SID_W-1:0] ST_LG_MEAN  = 5'd8;
  localparam logic [SID_W-1:0] ST_LG_MIN   = 5'd9;
  localparam logic [SID_W-1:0] ST_LG_MAX   = 5'd10;
  localparam logic [SID_W-1:0] ST_LG_PCT   = 5'd11;
  localparam logic [SID_W-1:0] ST_SM_CNT   = 5'd12;
  localparam logic [SID_W-1:0] ST_SM_BASES = 5'd13;
  localparam logic [SID_W-1:0] ST_SM_MEAN  = 5'd14;
  localparam logic [SID_W-1:0] ST_SM_MIN   = 5'd15;
  localparam logic [SID_W-1:0] ST_SM_MAX   = 5'd16;
  localparam logic [SID_W-1:0] ST_SM_PCT   = 5'd17;
  localparam logic [SID_W-1:0] ST_RD_STORE = 5'd18;
  localparam logic [SID_W-1:0] ST_RD_CTG   = 5'd19;
  localparam logic [SID_W-1:0] ST_RD_LG    = 5'd20;
  localparam logic [SID_W-1:0] ST_RD_SM    = 5'd21;
  localparam logic [SID_W-1:0] ST_SINGLES  = 5'd22;

  typedef struct packed {
    logic load;
    logic pass_init;
    logic pass_run;
    logic scan_mode;
    logic srch_init;
    logic commit;
    logic div_start;
    logic emit;
    logic clear;
  } ctgs_cmd_t;

  typedef struct packed {
    logic pass_done;
    logic last_bit;
    logic needs_div;
    logic div_done;
    logic last_sid;
  } ctgs_sts_t;
endpackage
`default_nettype wire

/* sv/contig_length_n50_stats_unit.sv */
// Contig length statistics unit with N50: top level.
// Depends on ctgs_pkg, ctgs_ctrl, ctgs_dp (and ctgs_div below it).
// Loading takes one cycle per contig, back to back, while busy is low. The request that
// carries last_contig starts the run: one scan pass over the length store, then 31 N50
// search passes, one per bit of the length, then the 23 statistics, one per cycle on
// out_valid, except the five means and percents, which each wait for the shared
// bit-serial divider. Results cannot be held off. Up to MAX_CONTIGS contigs are kept;
// further ones are dropped.
`default_nettype none
module contig_length_n50_stats_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [ctgs_pkg::LEN_W-1:0]    in_contig_length,
  input  wire logic [ctgs_pkg::RD_W-1:0]     in_read_count,
  input  wire logic                          in_last_contig,
  output logic                               out_valid,
  output logic [ctgs_pkg::SID_W-1:0]         out_stat_id,
  output logic [ctgs_pkg::VAL_W-1:0]         out_stat_value,
  output logic                               out_last_stat,
  input  wire logic                          cfg_we,
  input  wire logic [0:0]                    cfg_index,
  input  wire logic [ctgs_pkg::CFGD_W-1:0]   cfg_wdata
);
  ctgs_pkg::ctgs_cmd_t cmd;
  ctgs_pkg::ctgs_sts_t sts;
  logic busy_i;

  ctgs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .last_contig (in_last_contig),
    .busy        (busy_i),
    .cmd         (cmd),
    .sts         (sts)
  );

  ctgs_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_contig_length (in_contig_length),
    .in_read_count    (in_read_count),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_stat_id      (out_stat_id),
    .out_stat_value   (out_stat_value),
    .out_last_stat    (out_last_stat)
  );

  assign busy = busy_i;
endmodule
`default_nettype wire

/* sv/ctgs_div.sv */
// Restoring divider, one quotient bit per cycle; divide by zero gives 0.
// Depends on ctgs_pkg.
`default_nettype none
module ctgs_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [ctgs_pkg::NUM_W-1:0]  num,
  input  wire logic [ctgs_pkg::SUM_W-1:0]  den,
  output logic                             done,
  output logic [ctgs_pkg::VAL_W-1:0]       quo
);
  localparam int CW = $clog2(ctgs_pkg::NUM_W + 1);

  logic [ctgs_pkg::SUM_W:0]   rem_r, rem_nxt, rem_sh;
  logic [ctgs_pkg::NUM_W-1:0] quo_r, quo_nxt;
  logic [ctgs_pkg::SUM_W-1:0] den_r;
  logic [CW-1:0]              cnt_r;
  logic                       run_r, dz_r, done_r;

  always_comb begin
    rem_sh = {rem_r[ctgs_pkg::SUM_W-1:0], quo_r[ctgs_pkg::NUM_W-1]};
    if (rem_sh >= {1'b0, den_r}) begin
      rem_nxt = rem_sh - {1'b0, den_r};
      quo_nxt = {quo_r[ctgs_pkg::NUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh;
      quo_nxt = {quo_r[ctgs_pkg::NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(ctgs_pkg::NUM_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
      dz_r  <= (den == '0);
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = dz_r ? '0 : quo_r[ctgs_pkg::VAL_W-1:0];
endmodule
`default_nettype wire

/* sv/ctgs_dp.sv */
// Datapath: length store, running sums, min/max scan, N50 bit search and result mux.
// Depends on ctgs_pkg and ctgs_div.
`default_nettype none
module ctgs_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ctgs_pkg::ctgs_cmd_t           cmd,
  output ctgs_pkg::ctgs_sts_t                sts,
  input  wire logic [ctgs_pkg::LEN_W-1:0]    in_contig_length,
  input  wire logic [ctgs_pkg::RD_W-1:0]     in_read_count,
  input  wire logic                          cfg_we,
  input  wire logic [0:0]                    cfg_index,
  input  wire logic [ctgs_pkg::CFGD_W-1:0]   cfg_wdata,
  output logic                               out_valid,
  output logic [ctgs_pkg::SID_W-1:0]         out_stat_id,
  output logic [ctgs_pkg::VAL_W-1:0]         out_stat_value,
  output logic                               out_last_stat
);
  localparam int LW = ctgs_pkg::LEN_W;
  localparam int CW = ctgs_pkg::CNT_W;
  localparam int SW = ctgs_pkg::SUM_W;
  localparam int RW = ctgs_pkg::RSUM_W;
  localparam int VW = ctgs_pkg::VAL_W;

  logic [LW-1:0] mem [ctgs_pkg::MAX_CONTIGS];
  logic [LW-1:0] rd_q;

  logic [LW-1:0] thr_r;
  logic [ctgs_pkg::CFGD_W-1:0] ris_r;
  logic [CW-1:0] cnt_r, lg_cnt_r, sm_cnt_r, idx_r;
  logic [SW-1:0] tot_r, lg_bases_r, sm_bases_r, acc_r;
  logic [RW-1:0] rds_r, lg_rds_r, sm_rds_r;
  logic [LW-1:0] min_r, max_r, lmin_r, lmax_r, smin_r, smax_r, cand_r;
  logic          any_r, lany_r, sany_r, rd_vld_r;
  logic [ctgs_pkg::BIT_W-1:0] bit_r;
  logic [ctgs_pkg::SID_W-1:0] sid_r;
  logic          ov_r, olast_r;
  logic [ctgs_pkg::SID_W-1:0] oid_r;
  logic [VW-1:0] oval_r;

  logic          wr_en, issue, is_lg;
  logic [LW-1:0] test;
  logic [SW-1:0] half;
  logic [RW:0]   sgl;
  logic [SW-1:0] d_a, d_den;
  logic [ctgs_pkg::KMUL_W-1:0] d_k;
  logic [ctgs_pkg::NUM_W-1:0]  d_num;
  logic          d_done;
  logic [VW-1:0] d_q, val;

  assign wr_en = cmd.load && (cnt_r < CW'(ctgs_pkg::MAX_CONTIGS));
  assign issue = cmd.pass_run && (idx_r < cnt_r);
  assign is_lg = in_contig_length >= thr_r;
  assign test  = cand_r | (LW'(1) << bit_r);
  assign half  = tot_r >> 1;

  always_ff @(posedge clk) begin
    if (wr_en) mem[cnt_r[ctgs_pkg::ADDR_W-1:0]] <= in_contig_length;
    rd_q <= mem[idx_r[ctgs_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= LW'(10000);
      ris_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ctgs_pkg::CFG_THRESH: thr_r <= cfg_wdata[LW-1:0];
        ctgs_pkg::CFG_READS:  ris_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      cnt_r <= '0; tot_r <= '0; rds_r <= '0;
      lg_cnt_r <= '0; lg_bases_r <= '0; lg_rds_r <= '0;
      sm_cnt_r <= '0; sm_bases_r <= '0; sm_rds_r <= '0;
    end else if (wr_en) begin
      cnt_r <= cnt_r + 1'b1;
      tot_r <= tot_r + SW'(in_contig_length);
      rds_r <= rds_r + RW'(in_read_count);
      if (is_lg) begin
        lg_cnt_r   <= lg_cnt_r + 1'b1;
        lg_bases_r <= lg_bases_r + SW'(in_contig_length);
        lg_rds_r   <= lg_rds_r + RW'(in_read_count);
      end else begin
        sm_cnt_r   <= sm_cnt_r + 1'b1;
        sm_bases_r <= sm_bases_r + SW'(in_contig_length);
        sm_rds_r   <= sm_rds_r + RW'(in_read_count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0; rd_vld_r <= 1'b0;
      any_r <= 1'b0; lany_r <= 1'b0; sany_r <= 1'b0;
    end else if (cmd.pass_init) begin
      idx_r <= '0; rd_vld_r <= 1'b0;
      if (cmd.scan_mode) begin
        any_r <= 1'b0; lany_r <= 1'b0; sany_r <= 1'b0;
      end
    end else begin
      if (issue) idx_r <= idx_r + 1'b1;
      rd_vld_r <= issue;
      if (rd_vld_r && cmd.scan_mode) begin
        any_r <= 1'b1;
        if (rd_q >= thr_r) lany_r <= 1'b1;
        else sany_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pass_init) acc_r <= '0;
    else if (rd_vld_r && !cmd.scan_mode && rd_q >= test) acc_r <= acc_r + SW'(rd_q);
    if (rd_vld_r && cmd.scan_mode) begin
      if (!any_r || rd_q < min_r) min_r <= rd_q;
      if (!any_r || rd_q > max_r) max_r <= rd_q;
      if (rd_q >= thr_r) begin
        if (!lany_r || rd_q < lmin_r) lmin_r <= rd_q;
        if (!lany_r || rd_q > lmax_r) lmax_r <= rd_q;
      end else begin
        if (!sany_r || rd_q < smin_r) smin_r <= rd_q;
        if (!sany_r || rd_q > smax_r) smax_r <= rd_q;
      end
    end
    if (cmd.srch_init) begin
      cand_r <= '0;
      bit_r  <= ctgs_pkg::BIT_W'(LW - 1);
    end else if (cmd.commit) begin
      if (acc_r >= half) cand_r <= test;
      bit_r <= bit_r - 1'b1;
    end
  end

  // divider operands
  always_comb begin
    d_a = tot_r; d_k = 14'd100; d_den = SW'(cnt_r);
    case (sid_r)
      ctgs_pkg::ST_LG_MEAN: begin d_a = lg_bases_r; d_den = SW'(lg_cnt_r); end
      ctgs_pkg::ST_LG_PCT:  begin d_a = lg_bases_r; d_k = 14'd10000; d_den = tot_r; end
      ctgs_pkg::ST_SM_MEAN: begin d_a = sm_bases_r; d_den = SW'(sm_cnt_r); end
      ctgs_pkg::ST_SM_PCT:  begin d_a = sm_bases_r; d_k = 14'd10000; d_den = tot_r; end
      default: ;
    endcase
    d_num = ctgs_pkg::NUM_W'(d_a) * ctgs_pkg::NUM_W'(d_k) + ctgs_pkg::NUM_W'(d_den >> 1);
  end

  ctgs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (d_num),
    .den   (d_den),
    .done  (d_done),
    .quo   (d_q)
  );

  assign sgl = ({1'b0, RW'(ris_r)} > {1'b0, rds_r}) ?
               ({1'b0, RW'(ris_r)} - {1'b0, rds_r}) : '0;

  // a zero half-total is met by the longest contig
  always_comb begin
    case (sid_r)
      ctgs_pkg::ST_CNT:      val = VW'(cnt_r);
      ctgs_pkg::ST_BASES:    val = VW'(tot_r);
      ctgs_pkg::ST_MIN:      val = any_r ? VW'(min_r) : '0;
      ctgs_pkg::ST_MAX:      val = any_r ? VW'(max_r) : '0;
      ctgs_pkg::ST_N50:      val = (cnt_r == '0) ? '0 :
                                   (half == '0) ? VW'(max_r) : VW'(cand_r);
      ctgs_pkg::ST_LG_CNT:   val = VW'(lg_cnt_r);
      ctgs_pkg::ST_LG_BASES: val = VW'(lg_bases_r);
      ctgs_pkg::ST_LG_MIN:   val = lany_r ? VW'(lmin_r) : '0;
      ctgs_pkg::ST_LG_MAX:   val = lany_r ? VW'(lmax_r) : '0;
      ctgs_pkg::ST_SM_CNT:   val = VW'(sm_cnt_r);
      ctgs_pkg::ST_SM_BASES: val = VW'(sm_bases_r);
      ctgs_pkg::ST_SM_MIN:   val = sany_r ? VW'(smin_r) : '0;
      ctgs_pkg::ST_SM_MAX:   val = sany_r ? VW'(smax_r) : '0;
      ctgs_pkg::ST_RD_STORE: val = VW'(ris_r);
      ctgs_pkg::ST_RD_CTG:   val = VW'(rds_r);
      ctgs_pkg::ST_RD_LG:    val = VW'(lg_rds_r);
      ctgs_pkg::ST_RD_SM:    val = VW'(sm_rds_r);
      ctgs_pkg::ST_SINGLES:  val = VW'(sgl);
      default:               val = d_q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      sid_r <= '0;
    end else begin
      ov_r <= cmd.emit;
      if (cmd.clear) sid_r <= '0;
      else if (cmd.emit) sid_r <= sid_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      oid_r   <= sid_r;
      oval_r  <= val;
      olast_r <= (sid_r == ctgs_pkg::ST_SINGLES);
    end
  end

  assign sts.pass_done = !(idx_r < cnt_r) && !rd_vld_r;
  assign sts.last_bit  = (bit_r == '0);
  assign sts.needs_div = (sid_r == ctgs_pkg::ST_MEAN) || (sid_r == ctgs_pkg::ST_LG_MEAN) ||
                         (sid_r == ctgs_pkg::ST_LG_PCT) || (sid_r == ctgs_pkg::ST_SM_MEAN) ||
                         (sid_r == ctgs_pkg::ST_SM_PCT);
  assign sts.div_done  = d_done;
  assign sts.last_sid  = (sid_r == ctgs_pkg::ST_SINGLES);

  assign out_valid      = ov_r;
  assign out_stat_id    = oid_r;
  assign out_stat_value = oval_r;
  assign out_last_stat  = olast_r;
endmodule
`default_nettype wire

/* sv/ctgs_ctrl.sv */
// Controller: load, min/max scan, N50 bit search passes and result emission.
// Depends on ctgs_pkg.
`default_nettype none
module ctgs_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 last_contig,
  output logic                      busy,
  output ctgs_pkg::ctgs_cmd_t       cmd,
  input  wire ctgs_pkg::ctgs_sts_t  sts
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_SRCH = 5'b00100,
    S_EMIT = 5'b01000,
    S_DIVW = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_contig) begin
            cmd.pass_init = 1'b1;
            cmd.scan_mode = 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_mode = 1'b1;
        cmd.pass_run = 1'b1;
        if (sts.pass_done) begin
          cmd.pass_init = 1'b1;
          cmd.scan_mode = 1'b0;
          cmd.srch_init = 1'b1;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        cmd.pass_run = 1'b1;
        if (sts.pass_done) begin
          cmd.commit = 1'b1;
          cmd.pass_init = 1'b1;
          if (sts.last_bit) state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.needs_div) begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIVW;
        end else begin
          cmd.emit = 1'b1;
          if (sts.last_sid) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_DIVW: begin
        if (sts.div_done) begin
          cmd.emit = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);
endmodule
`default_nettype wire
